/* src/evw_pkg.sv */
// Shared types, widths and codes for the epsilon vertex weld block.
package evw_pkg;

   localparam int MAX_UNIQUE = 4096;
   localparam int IDX_W = $clog2(MAX_UNIQUE);
   localparam int CNT_W = $clog2(MAX_UNIQUE + 1);

   localparam int COORD_W = 32;
   localparam int ENTRY_W = 3 * COORD_W;
   localparam int RADIUS_W = 40;
   localparam int UIDX_W = 12;
   localparam int STATUS_W = 2;

   // An axis difference of 2^21 or more squares to more than any 40-bit radius.
   localparam int AXIS_W = 21;
   localparam int SQ_W = 2 * AXIS_W;
   localparam int SUM_W = SQ_W + 2;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 40'd42;

   localparam logic [STATUS_W-1:0] STATUS_MATCH = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEW   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RSVD  = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                       start_of_mesh;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
   } req_type;

   typedef struct packed {
      logic [UIDX_W-1:0]   unique_index;
      logic [STATUS_W-1:0] weld_status;
   } rsp_type;

   // Classified request: coordinates in offset binary so that unsigned
   // order matches signed order.
   typedef struct packed {
      logic               clear;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } job_type;

   function automatic logic [COORD_W-1:0] to_offset(input logic signed [COORD_W-1:0] v);
      return {~v[COORD_W-1], v[COORD_W-2:0]};
   endfunction

endpackage

/* src/evw_front.sv */
// Front end: accepts requests, converts them to offset binary and queues them.
module evw_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  evw_pkg::req_type req_data,
   output logic             job_vld,
   input  logic             job_pop,
   output evw_pkg::job_type job_data
);
   import evw_pkg::*;

   job_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                wr_en;
   logic                rd_en;
   job_type             job_new;

   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign job_vld = (cnt_ff != '0);
   assign wr_en   = push && !full;
   assign rd_en   = job_pop && job_vld;
   assign job_data = queue_ff[rd_ptr_ff];

   always_comb begin
      job_new.clear = req_data.start_of_mesh;
      job_new.x     = to_offset(req_data.pos_x);
      job_new.y     = to_offset(req_data.pos_y);
      job_new.z     = to_offset(req_data.pos_z);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

/* src/evw_back.sv */
// Back end: scans the unique vertex table, appends new vertices, holds the result.
module evw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_vld,
   output logic                          job_pop,
   input  evw_pkg::job_type              job_data,
   input  logic                          csr_wr_en,
   input  logic [evw_pkg::RADIUS_W-1:0]  csr_wr_data,
   output logic                          empty,
   input  logic                          pop,
   output evw_pkg::rsp_type              rsp_data
);
   import evw_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic [RADIUS_W-1:0]  radius_ff;
   job_type              cur_ff;
   rsp_type              res_ff, res_in;
   rsp_type              out_ff;
   logic                 out_vld_ff, out_vld_in;

   logic [ENTRY_W-1:0]   mem_ff [MAX_UNIQUE];
   logic [ENTRY_W-1:0]   rd_data_ff;

   logic                 a_vld_ff, b_vld_ff, c_vld_ff;
   logic [IDX_W-1:0]     a_idx_ff, b_idx_ff, c_idx_ff;
   logic [2:0][AXIS_W-1:0] diff_ff, diff_in;
   logic                 b_over_ff, b_over_in;
   logic [2:0][SQ_W-1:0] sq_ff, sq_in;
   logic                 c_over_ff;

   logic                 issue;
   logic                 match;
   logic                 exhausted;
   logic                 table_full;
   logic                 wr_en;
   logic                 move_out;
   logic                 keep;
   logic [SUM_W-1:0]     sum;
   logic [2:0][COORD_W-1:0] stored;
   logic [2:0][COORD_W-1:0] probe;
   logic [COORD_W-1:0]   abs_d;

   assign empty    = !out_vld_ff;
   assign rsp_data = out_ff;

   assign job_pop    = (state_ff == ST_IDLE) && job_vld;
   assign issue      = (state_ff == ST_SCAN) && (issue_ff < scan_cnt_ff);
   assign sum        = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   assign match      = c_vld_ff && !c_over_ff && (sum <= SUM_W'(radius_ff));
   assign exhausted  = (state_ff == ST_SCAN) && !issue && !a_vld_ff && !b_vld_ff && !c_vld_ff;
   assign table_full = (scan_cnt_ff == CNT_W'(MAX_UNIQUE));
   assign wr_en      = exhausted && !table_full;
   assign move_out   = (state_ff == ST_DONE) && (!out_vld_ff || pop);
   // Stages in flight are dropped once the earliest match is found.
   assign keep       = (state_ff == ST_SCAN) && !match;

   // Stage B: per-axis absolute differences, truncated to AXIS_W bits with an overflow flag.
   always_comb begin
      stored[0] = rd_data_ff[3*COORD_W-1:2*COORD_W];
      stored[1] = rd_data_ff[2*COORD_W-1:COORD_W];
      stored[2] = rd_data_ff[COORD_W-1:0];
      probe[0]  = cur_ff.x;
      probe[1]  = cur_ff.y;
      probe[2]  = cur_ff.z;
      b_over_in = 1'b0;
      abs_d     = '0;
      for (int k = 0; k < 3; k++) begin
         abs_d = (probe[k] >= stored[k]) ? probe[k] - stored[k] : stored[k] - probe[k];
         diff_in[k] = abs_d[AXIS_W-1:0];
         if (abs_d[COORD_W-1:AXIS_W] != '0) begin
            b_over_in = 1'b1;
         end
      end
   end

   // Stage C: squares.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = diff_ff[k] * diff_ff[k];
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_cnt_in = scan_cnt_ff;
      issue_in    = issue_ff;
      res_in      = res_ff;
      out_vld_in  = out_vld_ff;
      if (pop && out_vld_ff) begin
         out_vld_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (job_vld) begin
               scan_cnt_in = job_data.clear ? '0 : count_ff;
               issue_in    = '0;
               if (job_data.clear) begin
                  count_in = '0;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               issue_in = issue_ff + 1'b1;
            end
            if (match) begin
               res_in.unique_index = UIDX_W'(c_idx_ff);
               res_in.weld_status  = STATUS_MATCH;
               state_in = ST_DONE;
            end else if (exhausted) begin
               if (table_full) begin
                  res_in.unique_index = '0;
                  res_in.weld_status  = STATUS_FULL;
               end else begin
                  res_in.unique_index = UIDX_W'(scan_cnt_ff);
                  res_in.weld_status  = STATUS_NEW;
                  count_in = scan_cnt_ff + 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (move_out) begin
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         radius_ff  <= RADIUS_RESET;
         out_vld_ff <= 1'b0;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         out_vld_ff <= out_vld_in;
         a_vld_ff   <= issue && keep;
         b_vld_ff   <= a_vld_ff && keep;
         c_vld_ff   <= b_vld_ff && keep;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      issue_ff    <= issue_in;
      res_ff      <= res_in;
      if (job_pop) begin
         cur_ff <= job_data;
      end
      if (move_out) begin
         out_ff <= res_ff;
      end
      a_idx_ff  <= issue_ff[IDX_W-1:0];
      b_idx_ff  <= a_idx_ff;
      c_idx_ff  <= b_idx_ff;
      diff_ff   <= diff_in;
      b_over_ff <= b_over_in;
      sq_ff     <= sq_in;
      c_over_ff <= b_over_ff;
   end

   // Unique vertex table: one read port for the scan, one write port for appends.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem_ff[issue_ff[IDX_W-1:0]];
      end
      if (wr_en) begin
         mem_ff[scan_cnt_ff[IDX_W-1:0]] <= {cur_ff.x, cur_ff.y, cur_ff.z};
      end
   end

endmodule

/* src/epsilon_vertex_weld.sv */
// Top level of the epsilon vertex weld block: front queue feeding the table scan engine.
// Throughput: one vertex at a time; the scan reads one stored vertex per cycle from the
// table's single read port.
// Reset empties the request queue, the result register and the table fill count and sets
// the weld radius to 42; the table contents are not cleared.
module epsilon_vertex_weld (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  evw_pkg::req_type              req_data,
   output logic                          empty,
   input  logic                          pop,
   output evw_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [evw_pkg::RADIUS_W-1:0]  csr_wr_data
);
   import evw_pkg::*;

   logic    job_vld;
   logic    job_pop;
   job_type job_data;

   evw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .job_vld  (job_vld),
      .job_pop  (job_pop),
      .job_data (job_data)
   );

   evw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_vld     (job_vld),
      .job_pop     (job_pop),
      .job_data    (job_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

endmodule

/* src/evw_checker.sv */
// Port-level checks for the epsilon vertex weld block, bound to the top level.
module evw_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          full,
   input logic                          empty,
   input logic                          pop,
   input evw_pkg::rsp_type              rsp_data
);
   import evw_pkg::*;

   // Nothing is queued or waiting right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("result or full flag set after reset");

   // A waiting result that is not taken stays the same.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("waiting result changed before it was taken");

   // The reserved status code is never produced.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_data.weld_status != STATUS_RSVD)
      else $error("reserved weld status on result");

   // A dropped vertex reports index zero.
   a_full_index: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.weld_status == STATUS_FULL |-> rsp_data.unique_index == '0)
      else $error("dropped vertex reported a nonzero index");

endmodule

bind epsilon_vertex_weld evw_checker u_evw_checker (.*);
